// ===== design/jb_pkg.sv =====
// Shared constants, codes and types for the join barrier.
// Depends on nothing; every design file refers to it by scoped names.
package jb_pkg;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned NUM_SLOTS    = 8;

  localparam int unsigned CH_W      = $clog2(NUM_CHANNELS);
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned NUM_W     = 31;
  localparam int unsigned CNT_W     = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned REC_AW    = SLOT_W + CH_W;
  localparam int unsigned REC_DEPTH = NUM_SLOTS * NUM_CHANNELS;

  localparam logic [1:0] ACT_SIGNAL   = 2'd0;
  localparam logic [1:0] ACT_CLR_SLOT = 2'd1;
  localparam logic [1:0] ACT_CLR_ALL  = 2'd2;

  // Request from the sequencer to the record store / compare unit.
  typedef struct packed {
    logic              we;
    logic [REC_AW-1:0] waddr;
    logic [NUM_W-1:0]  wdata;
    logic              re;
    logic [REC_AW-1:0] raddr;
    logic [NUM_W-1:0]  cmp_ref;
  } rec_req_t;

endpackage

// ===== design/multi_input_join_barrier_core.sv =====
// Join barrier top level: handshakes, slot flags, scan sequencer, output word.
// Depends on jb_pkg and jb_rec_store.
//
//   port group   dir  handshake               payload
//   cfg          in   cfg_we_i (no wait)      cfg_wdata_i (member mask)
//   in           in   in_valid_i/in_ready_o   action_i, channel_index_i, image_number_i
//   out          out  out_valid_o/out_ready_i group_image_number_o, member_count_o
//
// A member signal is recorded, then walks the slot's 16 channels through the one
// record read port and comparator, then closes.
// Clear actions, ignored signals and unused codes leave the sequencer idle.
// Reset clears flags, mask and control; the record store needs no clearing.
// A held output word stalls only the closing cycle of a completing signal.
module multi_input_join_barrier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jb_pkg::NUM_CHANNELS-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [jb_pkg::CH_W-1:0]         channel_index_i,
  input  logic [jb_pkg::NUM_W-1:0]        image_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [jb_pkg::NUM_W-1:0]        group_image_number_o,
  output logic [jb_pkg::CNT_W-1:0]        member_count_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [jb_pkg::CH_W-1:0] LAST_CH = jb_pkg::CH_W'(jb_pkg::NUM_CHANNELS - 1);

  logic [1:0]                      state_q;
  logic [jb_pkg::NUM_CHANNELS-1:0] mask_q;
  logic [jb_pkg::NUM_CHANNELS-1:0] flags_q [jb_pkg::NUM_SLOTS];
  logic [jb_pkg::CH_W-1:0]         ch_q;
  logic [jb_pkg::NUM_W-1:0]        num_q;
  logic [jb_pkg::SLOT_W-1:0]       slot_q;
  logic [jb_pkg::CH_W:0]           rd_cnt_q;
  logic                            chk_vld_q;
  logic [jb_pkg::CH_W-1:0]         chk_idx_q;
  logic [jb_pkg::CNT_W-1:0]        mcount_q;
  logic                            out_valid_q;
  logic [jb_pkg::NUM_W-1:0]        out_num_q;
  logic [jb_pkg::CNT_W-1:0]        out_cnt_q;

  jb_pkg::rec_req_t                rec_req;
  logic                            stale;
  logic                            accept;
  logic                            in_member;
  logic [jb_pkg::SLOT_W-1:0]       in_slot;
  logic                            clr_stale;
  logic                            full;
  logic                            out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_slot    = image_number_i[jb_pkg::SLOT_W-1:0];
  assign in_member  = mask_q[channel_index_i];
  assign out_free   = ~out_valid_q | out_ready_i;
  assign full       = ((flags_q[slot_q] & mask_q) == mask_q);

  // Stale neighbor: set, member, not the signaler, older recorded number.
  assign clr_stale = chk_vld_q && (chk_idx_q != ch_q) && mask_q[chk_idx_q]
                     && flags_q[slot_q][chk_idx_q] && stale;

  always_comb begin
    rec_req.we      = accept && (action_i == jb_pkg::ACT_SIGNAL) && in_member;
    rec_req.waddr   = {in_slot, channel_index_i};
    rec_req.wdata   = image_number_i;
    rec_req.re      = (state_q == ST_SCAN) && !rd_cnt_q[jb_pkg::CH_W];
    rec_req.raddr   = {slot_q, rd_cnt_q[jb_pkg::CH_W-1:0]};
    rec_req.cmp_ref = num_q;
  end

  jb_rec_store u_rec_store (
    .clk_i   (clk_i),
    .req_i   (rec_req),
    .stale_o (stale)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (rec_req.we) begin
            rd_cnt_q  <= '0;
            chk_vld_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!rd_cnt_q[jb_pkg::CH_W]) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          chk_vld_q <= !rd_cnt_q[jb_pkg::CH_W];
          if (chk_vld_q && (chk_idx_q == LAST_CH)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!full || out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item context and running member count
  always_ff @(posedge clk_i) begin
    if (rec_req.we) begin
      ch_q     <= channel_index_i;
      num_q    <= image_number_i;
      slot_q   <= in_slot;
      mcount_q <= '0;
    end else if (chk_vld_q && (state_q == ST_SCAN)) begin
      mcount_q <= mcount_q + jb_pkg::CNT_W'(mask_q[chk_idx_q]);
    end
    if (state_q == ST_SCAN) begin
      chk_idx_q <= rd_cnt_q[jb_pkg::CH_W-1:0];
    end
  end

  // Membership and slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int s = 0; s < jb_pkg::NUM_SLOTS; s++) begin
        flags_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
        // a channel whose membership changes loses its flag everywhere
        for (int s = 0; s < jb_pkg::NUM_SLOTS; s++) begin
          flags_q[s] <= flags_q[s] & ~(mask_q ^ cfg_wdata_i);
        end
      end else if (accept) begin
        unique case (action_i)
          jb_pkg::ACT_SIGNAL: begin
            if (in_member) begin
              flags_q[in_slot][channel_index_i] <= 1'b1;
            end
          end
          jb_pkg::ACT_CLR_SLOT: flags_q[in_slot] <= '0;
          jb_pkg::ACT_CLR_ALL: begin
            for (int s = 0; s < jb_pkg::NUM_SLOTS; s++) begin
              flags_q[s] <= '0;
            end
          end
          default: ;
        endcase
      end else if ((state_q == ST_SCAN) && clr_stale) begin
        flags_q[slot_q][chk_idx_q] <= 1'b0;
      end else if ((state_q == ST_DONE) && full && out_free) begin
        flags_q[slot_q] <= '0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && full && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && full && out_free) begin
      out_num_q <= num_q;
      out_cnt_q <= mcount_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign group_image_number_o = out_num_q;
  assign member_count_o       = out_cnt_q;

endmodule

// ===== design/jb_rec_store.sv =====
// Recorded image numbers per slot and channel, with the shared stale compare.
// Depends on jb_pkg.
module jb_rec_store (
  input  logic             clk_i,
  input  jb_pkg::rec_req_t req_i,
  output logic             stale_o
);

  logic [jb_pkg::NUM_W-1:0] mem_q [jb_pkg::REC_DEPTH];
  logic [jb_pkg::NUM_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  // Recorded number older than the one just signaled.
  assign stale_o = (rd_q < req_i.cmp_ref);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for multi_input_join_barrier_core: directed and random words,
// with a scoreboard class that predicts the group words. Depends on jb_pkg and the core.
// Plain tasks drive the input and config ports, and the receiver stalls in its own process.

typedef struct packed {
  logic [jb_pkg::NUM_W-1:0] image;
  logic [jb_pkg::CNT_W-1:0] count;
} group_word_t;

class join_scoreboard;
  logic [jb_pkg::NUM_CHANNELS-1:0] members;
  logic [jb_pkg::NUM_CHANNELS-1:0] flags [jb_pkg::NUM_SLOTS];
  logic [jb_pkg::NUM_W-1:0]        last_num [jb_pkg::NUM_SLOTS * jb_pkg::NUM_CHANNELS];
  group_word_t                     groups_q [$];
  int                              errors;

  function new();
    members = '0;
    errors  = 0;
    foreach (flags[s]) flags[s] = '0;
    foreach (last_num[i]) last_num[i] = '0;
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // A membership change drops the flags of the channels that changed, in every slot.
  function void write_mask(logic [jb_pkg::NUM_CHANNELS-1:0] value);
    logic [jb_pkg::NUM_CHANNELS-1:0] changed;
    changed = members ^ value;
    members = value;
    foreach (flags[s]) flags[s] &= ~changed;
  endfunction

  function void note_input(logic [1:0] act, logic [jb_pkg::CH_W-1:0] ch,
                           logic [jb_pkg::NUM_W-1:0] num);
    int unsigned slot;
    int          c;
    group_word_t w;
    slot = num % jb_pkg::NUM_SLOTS;
    case (act)
      jb_pkg::ACT_CLR_SLOT: flags[slot] = '0;
      jb_pkg::ACT_CLR_ALL: begin
        foreach (flags[s]) flags[s] = '0;
      end
      jb_pkg::ACT_SIGNAL: begin
        if (members[ch]) begin
          flags[slot][ch] = 1'b1;
          last_num[slot * jb_pkg::NUM_CHANNELS + ch] = num;
          // other members holding an older image number are stale
          for (c = 0; c < jb_pkg::NUM_CHANNELS; c++) begin
            if (c != ch && members[c] && flags[slot][c] &&
                last_num[slot * jb_pkg::NUM_CHANNELS + c] < num)
              flags[slot][c] = 1'b0;
          end
          if ((flags[slot] & members) == members) begin
            flags[slot] = '0;
            w.image = num;
            w.count = jb_pkg::CNT_W'($countones(members));
            groups_q = {groups_q, w};
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [jb_pkg::NUM_W-1:0] image, logic [jb_pkg::CNT_W-1:0] count);
    group_word_t want;
    if (groups_q.size() == 0) begin
      report($sformatf("unexpected group word: image %0d count %0d", image, count));
      return;
    end
    want = groups_q.pop_front();
    if (want.image !== image || want.count !== count)
      report($sformatf("group word mismatch: expected image %0d count %0d, got image %0d count %0d",
                       want.image, want.count, image, count));
  endfunction

  function int pending();
    return groups_q.size();
  endfunction

  function void check_drained();
    if (groups_q.size() != 0)
      report($sformatf("%0d group words never arrived", groups_q.size()));
  endfunction
endclass

module tb;
  import jb_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         HOLD_CYCLES  = 1500;
  localparam int         PHASE_ITEMS  = 215;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [NUM_CHANNELS-1:0] cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              action_i;
  logic [CH_W-1:0]         channel_index_i;
  logic [NUM_W-1:0]        image_number_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [NUM_W-1:0]        group_image_number_o;
  logic [CNT_W-1:0]        member_count_o;

  join_scoreboard          sb;
  int                      snd_idle_pct;
  int                      rcv_stall_pct;
  bit                      hold_req;
  int                      phase_items;
  logic [NUM_CHANNELS-1:0] cur_mask;

  multi_input_join_barrier_core u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .channel_index_i      (channel_index_i),
    .image_number_i       (image_number_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .group_image_number_o (group_image_number_o),
    .member_count_o       (member_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o)
        sb.note_input(action_i, channel_index_i, image_number_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(group_image_number_o, member_count_o);
    end
  end

  task automatic idle_cycle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_word(logic [1:0] act, logic [CH_W-1:0] ch, logic [NUM_W-1:0] num);
    while ($urandom_range(0, 99) < snd_idle_pct) idle_cycle();
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    channel_index_i <= ch;
    image_number_i  <= num;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    phase_items++;
  endtask

  task automatic send_noise();
    send_word(2'($urandom_range(0, 3)), CH_W'($urandom_range(0, NUM_CHANNELS - 1)),
              NUM_W'($urandom));
  endtask

  // stop offering, wait for every group word, then let an ignored word finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mask(logic [NUM_CHANNELS-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.write_mask(value);
    cur_mask = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    write_mask('0);
    send_word(ACT_SIGNAL, 4'd0, '0);              // empty group: ignored
    write_mask(16'h8001);
    send_word(ACT_SIGNAL, 4'd0, NUM_MAX);
    send_word(ACT_SIGNAL, 4'd5, NUM_MAX);         // non-member
    send_word(ACT_SIGNAL, 4'd0, NUM_MAX);         // repeated signal
    send_word(ACT_SIGNAL, 4'd15, NUM_MAX);
    send_word(ACT_SIGNAL, 4'd0, 31'd3);
    send_word(ACT_SIGNAL, 4'd15, 31'd11);         // drops ch0 as stale
    send_word(ACT_SIGNAL, 4'd0, 31'd11);
    send_word(ACT_SIGNAL, 4'd15, 31'd14);
    send_word(ACT_SIGNAL, 4'd0, 31'd6);           // older number keeps ch15
    send_word(ACT_SIGNAL, 4'd0, 31'd4);
    send_word(ACT_CLR_SLOT, 4'd9, 31'd12);
    send_word(ACT_SIGNAL, 4'd15, 31'd4);
    send_word(ACT_SIGNAL, 4'd0, 31'd4);
    send_word(ACT_SIGNAL, 4'd0, 31'd5);
    send_word(ACT_CLR_ALL, 4'd3, '0);
    send_word(ACT_UNUSED, 4'd0, 31'd5);
    send_word(ACT_SIGNAL, 4'd15, 31'd5);
    send_word(ACT_SIGNAL, 4'd0, 31'd5);
    send_word(ACT_SIGNAL, 4'd0, 31'd2);
    write_mask(16'h8000);                         // ch0 leaves: its flag drops
    write_mask(16'h8001);
    send_word(ACT_SIGNAL, 4'd15, 31'd2);
    send_word(ACT_SIGNAL, 4'd0, 31'd2);
  endtask

  // mostly complete groups in random order, some partial groups and noise words
  task automatic run_phase(int quota, bit hold_off, bit pause);
    int unsigned      chans [$];
    int unsigned      kind;
    int unsigned      tmp;
    int unsigned      j;
    int               i;
    int               c;
    bit               hold_done;
    bit               pause_done;
    logic [NUM_W-1:0] num;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    phase_items = 0;
    while (phase_items < quota) begin
      if (hold_off && !hold_done && phase_items >= 60) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (pause && !pause_done && phase_items >= 100) begin
        settle();
        pause_done = 1'b1;
      end
      chans = {};
      for (c = 0; c < NUM_CHANNELS; c++)
        if (cur_mask[c]) chans = {chans, c};
      for (i = chans.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = chans[i];
        chans[i] = chans[j];
        chans[j] = tmp;
      end
      num  = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 63)) : NUM_W'($urandom);
      kind = $urandom_range(0, 99);
      if (chans.size() == 0 || kind >= 90) begin
        send_noise();
      end else begin
        if (kind >= 75) begin
          tmp = $urandom_range(1, chans.size());
          while (chans.size() > tmp) void'(chans.pop_back());
        end
        foreach (chans[k]) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send_word(ACT_SIGNAL, CH_W'(chans[k]), num);
        end
      end
    end
  endtask

  initial begin
    logic [NUM_CHANNELS-1:0] mask;
    int                      p;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_SIGNAL;
    channel_index_i = '0;
    image_number_i  = '0;
    cur_mask        = '0;
    sb              = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (p = 0; p < 8; p++) begin
      snd_idle_pct  = (p % 4 == 1) ? 81 : (p % 4 == 3) ? 24 : 0;
      rcv_stall_pct = (p % 4 == 2) ? 81 : (p % 4 == 3) ? 24 : 0;
      case (p)
        0, 7:    mask = '1;
        2:       mask = NUM_CHANNELS'(1) << $urandom_range(0, NUM_CHANNELS - 1);
        4:       mask = '0;
        5:       mask = NUM_CHANNELS'($urandom & $urandom);
        6:       mask = NUM_CHANNELS'($urandom | $urandom);
        default: mask = NUM_CHANNELS'($urandom);
      endcase
      write_mask(mask);
      run_phase((p == 4) ? 30 : PHASE_ITEMS, p == 0, p == 1);
    end
    settle();
    sb.check_drained();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
